// File: rtl/wspo_pkg.sv
// Package for the wheel speed PID / odometry core.
// Holds widths, constants, codes, the sequencer state type and the multiplier request.
// No dependencies.
package wspo_pkg;

    localparam int TICKS_PER_SECOND_DEF = 1000;

    localparam int MAG_W  = 49;
    localparam int GAIN_W = 24;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int NUM_W  = 40;
    localparam int DEN_W  = 24;

    localparam logic [15:0]      CNT_MID  = 16'd32767;
    localparam logic [22:0]      DUTY_MAX = 23'd5242880;
    localparam logic [DEN_W-1:0] CMP_DEN  = 24'd6553600;

    localparam logic [2:0] CFG_PROP   = 3'd0;
    localparam logic [2:0] CFG_INTEG  = 3'd1;
    localparam logic [2:0] CFG_DERIV  = 3'd2;
    localparam logic [2:0] CFG_FFWD   = 3'd3;
    localparam logic [2:0] CFG_PERIOD = 3'd4;
    localparam logic [2:0] CFG_MM     = 3'd5;
    localparam logic [2:0] CFG_UNUSED = 3'd6;

    localparam logic [2:0] DRV_FWD    = 3'd0;
    localparam logic [2:0] DRV_TURN   = 3'd1;
    localparam logic [2:0] DRV_ROTATE = 3'd2;
    localparam logic [2:0] DRV_BACK   = 3'd3;
    localparam logic [2:0] DRV_HALT   = 3'd4;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_NONE  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRAV_L,
        ST_TRAV_R,
        ST_SPEED,
        ST_RAMP,
        ST_ERR,
        ST_PTERM,
        ST_ITERM,
        ST_DTERM,
        ST_CLAMP,
        ST_SCALE,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [GAIN_W-1:0] mult;
    } t_mul_req;

endpackage

// File: rtl/wspo_mul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on wspo_pkg.
module wspo_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wspo_pkg::t_mul_req               i_req,
    output logic                             o_done,
    output logic [wspo_pkg::PROD_W-1:0]      o_prod
);
    import wspo_pkg::*;

    localparam int CW = $clog2(GAIN_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [PROD_W-1:0] r_acc;
    logic [GAIN_W-1:0] r_mult;
    logic [MAG_W-1:0]  r_mag;
    logic [MAG_W:0]    n_sum;
    logic [PROD_W-1:0] n_acc;

    always_comb begin
        n_sum = {1'b0, r_acc[PROD_W-1:GAIN_W]} + {1'b0, (r_mult[0] ? r_mag : '0)};
        n_acc = {n_sum, r_acc[GAIN_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_mult <= i_req.mult;
                r_mag  <= i_req.mag;
            end else if (r_busy) begin
                r_acc  <= n_acc;
                r_mult <= r_mult >> 1;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(GAIN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/wspo_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on wspo_pkg.
module wspo_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wspo_pkg::NUM_W-1:0]  i_num,
    input  logic [wspo_pkg::DEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [wspo_pkg::NUM_W-1:0]  o_quo
);
    import wspo_pkg::*;

    localparam int CW = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   n_sh;
    logic             n_ge;
    logic [DEN_W:0]   n_rem;

    always_comb begin
        n_sh  = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        n_ge  = n_sh >= {1'b0, r_den};
        n_rem = n_ge ? (n_sh - {1'b0, r_den}) : n_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[NUM_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: rtl/wheel_speed_pid_with_odometry_core.sv
// Wheel speed PID with odometry: top level, sequencer and state.
// Each request runs seven serial multiplies and two serial divides in sequence.
// A new request is taken only in idle, after the previous result is handed off;
// the multiplier and divider are single serial units shared by all steps.
// Reset (synchronous, active low) clears controller state and sets configuration registers to defaults.
// Depends on wspo_pkg, wspo_mul, wspo_div.
module wheel_speed_pid_with_odometry_core #(
    parameter int TICKS_PER_SECOND = wspo_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_left_count,
    input  logic [15:0] i_right_count,
    input  logic [15:0] i_accel_mm_s2,
    input  logic [2:0]  i_drive_mode,
    input  logic [1:0]  i_turn_dir,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_left_compare,
    output logic [15:0] o_right_compare,
    output logic        o_left_reverse,
    output logic        o_right_reverse,
    output logic [31:0] o_measured_speed,
    output logic [31:0] o_left_travel,
    output logic [31:0] o_right_travel,
    output logic [22:0] o_duty_percent
);
    import wspo_pkg::*;

    localparam logic [NUM_W-1:0]  TPS_NUM = NUM_W'(TICKS_PER_SECOND);
    localparam logic [NUM_W-1:0]  TPS2M1  = NUM_W'(2 * TICKS_PER_SECOND - 1);
    localparam logic [DEN_W-1:0]  TPS2    = DEN_W'(2 * TICKS_PER_SECOND);
    localparam logic [GAIN_W-1:0] TPS_G   = GAIN_W'(TICKS_PER_SECOND);

    t_state r_state, n_state;
    logic   r_launch;

    logic [23:0] r_kp, r_ki, r_kd, r_mm;
    logic [22:0] r_ff;
    logic [15:0] r_period;

    logic [15:0] r_lcnt, r_rcnt, r_accel;
    logic [2:0]  r_mode;
    logic [1:0]  r_dir;

    logic [31:0] r_target, r_last_err, r_ldist, r_rdist;
    logic [47:0] r_esum;
    logic        r_lback, r_rback;

    logic [40:0] r_dl, r_dr;
    logic [31:0] r_speed, r_err;
    logic [32:0] r_dval;
    logic [63:0] r_duty;
    logic [22:0] r_duty_c;
    logic [39:0] r_scale;

    logic        r_o_valid;
    logic [15:0] r_o_cmp;
    logic        r_o_lrev, r_o_rrev;
    logic [31:0] r_o_speed, r_o_ltrav, r_o_rtrav;
    logic [22:0] r_o_duty;

    t_mul_req          w_mreq;
    logic              w_mdone;
    logic [PROD_W-1:0] w_prod;
    logic              w_neg;
    logic              w_dstart;
    logic [NUM_W-1:0]  w_dnum;
    logic [DEN_W-1:0]  w_dden;
    logic              w_ddone;
    logic [NUM_W-1:0]  w_quo;

    logic [15:0] w_ldiff, w_rdiff, w_labs, w_rabs;
    logic [41:0] w_ssum, w_sabs;
    logic [31:0] w_eabs;
    logic [47:0] w_esabs;
    logic [32:0] w_dabs;
    logic [PROD_W:0] w_pos, w_negp, w_ps;
    logic [40:0] w_dl_new, w_dr_new, w_lt, w_rt;
    logic [PROD_W:0] w_sp_r;
    logic [64:0] w_sp_sh;
    logic [31:0] w_sp_sat;
    logic [39:0] w_x, w_xabs, w_step, w_tsum;
    logic [31:0] w_tsat;
    logic [32:0] w_ediff;
    logic [31:0] w_err;
    logic [48:0] w_esn;
    logic [47:0] w_esat;
    logic [63:0] w_gterm;
    logic        w_take;

    wspo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    wspo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_ldiff = r_lcnt - CNT_MID;
        w_rdiff = r_rcnt - CNT_MID;
        w_labs  = w_ldiff[15] ? (~w_ldiff + 16'd1) : w_ldiff;
        w_rabs  = w_rdiff[15] ? (~w_rdiff + 16'd1) : w_rdiff;
        w_ssum  = {r_dl[40], r_dl} + {r_dr[40], r_dr};
        w_sabs  = w_ssum[41] ? (~w_ssum + 42'd1) : w_ssum;
        w_eabs  = r_err[31] ? (~r_err + 32'd1) : r_err;
        w_esabs = r_esum[47] ? (~r_esum + 48'd1) : r_esum;
        w_dabs  = r_dval[32] ? (~r_dval + 33'd1) : r_dval;

        w_mreq.start = 1'b0;
        w_mreq.mag   = '0;
        w_mreq.mult  = '0;
        w_neg        = 1'b0;
        unique case (r_state)
            ST_TRAV_L: begin
                w_mreq.start = r_launch;
                w_mreq.mag   = MAG_W'(w_labs);
                w_mreq.mult  = r_mm;
                w_neg        = w_ldiff[15];
            end
            ST_TRAV_R: begin
                w_mreq.start = r_launch;
                w_mreq.mag   = MAG_W'(w_rabs);
                w_mreq.mult  = r_mm;
                w_neg        = w_rdiff[15];
            end
            ST_SPEED: begin
                w_mreq.start = r_launch;
                w_mreq.mag   = MAG_W'(w_sabs);
                w_mreq.mult  = TPS_G;
                w_neg        = w_ssum[41];
            end
            ST_PTERM: begin
                w_mreq.start = r_launch;
                w_mreq.mag   = MAG_W'(w_eabs);
                w_mreq.mult  = r_kp;
                w_neg        = r_err[31];
            end
            ST_ITERM: begin
                w_mreq.start = r_launch;
                w_mreq.mag   = MAG_W'(w_esabs);
                w_mreq.mult  = r_ki;
                w_neg        = r_esum[47];
            end
            ST_DTERM: begin
                w_mreq.start = r_launch;
                w_mreq.mag   = MAG_W'(w_dabs);
                w_mreq.mult  = r_kd;
                w_neg        = r_dval[32];
            end
            ST_SCALE: begin
                w_mreq.start = r_launch;
                w_mreq.mag   = MAG_W'(r_duty_c);
                w_mreq.mult  = GAIN_W'(r_period);
            end
            default: begin
            end
        endcase

        w_pos    = {1'b0, w_prod};
        w_negp   = ~w_pos + 1'b1;
        w_ps     = w_neg ? w_negp : w_pos;
        w_dl_new = w_neg ? w_pos[40:0] : w_negp[40:0];
        w_dr_new = w_ps[40:0];
        w_lt     = w_dl_new + 41'd32768;
        w_rt     = w_dr_new + 41'd32768;

        w_sp_r  = w_ps + (PROD_W + 1)'(256);
        w_sp_sh = w_sp_r[PROD_W:9];
        if (&w_sp_sh[64:31] || ~|w_sp_sh[64:31]) begin
            w_sp_sat = w_sp_sh[31:0];
        end else begin
            w_sp_sat = w_sp_sh[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end

        w_x      = {{7{r_accel[15]}}, r_accel, 17'd0} + TPS_NUM;
        w_xabs   = ~w_x + 40'd1;
        w_dstart = r_launch && (r_state == ST_RAMP || r_state == ST_CMP);
        w_dnum   = (r_state == ST_CMP) ? r_scale
                 : (w_x[39] ? (w_xabs + TPS2M1) : w_x);
        w_dden   = (r_state == ST_CMP) ? CMP_DEN : TPS2;
        w_step   = w_x[39] ? (~w_quo + 40'd1) : w_quo;
        w_tsum   = {{8{r_target[31]}}, r_target} + w_step;
        if (&w_tsum[39:31] || ~|w_tsum[39:31]) begin
            w_tsat = w_tsum[31:0];
        end else begin
            w_tsat = w_tsum[39] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end

        w_ediff = {r_target[31], r_target} - {r_speed[31], r_speed};
        unique case (w_ediff[32:31])
            2'b01:   w_err = 32'h7FFF_FFFF;
            2'b10:   w_err = 32'h8000_0000;
            default: w_err = w_ediff[31:0];
        endcase
        w_esn = {r_esum[47], r_esum} + {{17{w_err[31]}}, w_err};
        unique case (w_esn[48:47])
            2'b01:   w_esat = {1'b0, {47{1'b1}}};
            2'b10:   w_esat = {1'b1, 47'd0};
            default: w_esat = w_esn[47:0];
        endcase

        w_gterm = w_neg ? (~{7'd0, w_prod[PROD_W-1:16]} + 64'd1)
                        : {7'd0, w_prod[PROD_W-1:16]};

        w_take = !r_o_valid || i_ready;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_TRAV_L;
            ST_TRAV_L: if (w_mdone) n_state = ST_TRAV_R;
            ST_TRAV_R: if (w_mdone) n_state = ST_SPEED;
            ST_SPEED:  if (w_mdone) n_state = ST_RAMP;
            ST_RAMP:   if (w_ddone) n_state = ST_ERR;
            ST_ERR:    n_state = ST_PTERM;
            ST_PTERM:  if (w_mdone) n_state = ST_ITERM;
            ST_ITERM:  if (w_mdone) n_state = ST_DTERM;
            ST_DTERM:  if (w_mdone) n_state = ST_CLAMP;
            ST_CLAMP:  n_state = ST_SCALE;
            ST_SCALE:  if (w_mdone) n_state = ST_CMP;
            ST_CMP:    if (w_ddone) n_state = ST_OUT;
            ST_OUT:    if (w_take) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= (n_state != r_state);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
            r_ff     <= '0;
            r_period <= 16'hFFFF;
            r_mm     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PROP:   r_kp     <= i_cfg_wdata;
                CFG_INTEG:  r_ki     <= i_cfg_wdata;
                CFG_DERIV:  r_kd     <= i_cfg_wdata;
                CFG_FFWD:   r_ff     <= i_cfg_wdata[22:0];
                CFG_PERIOD: r_period <= i_cfg_wdata[15:0];
                CFG_MM:     r_mm     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_lcnt  <= i_left_count;
            r_rcnt  <= i_right_count;
            r_accel <= i_accel_mm_s2;
            r_mode  <= i_drive_mode;
            r_dir   <= i_turn_dir;
        end
        if (w_mdone) begin
            unique case (r_state)
                ST_TRAV_L: r_dl    <= w_dl_new;
                ST_TRAV_R: r_dr    <= w_dr_new;
                ST_SPEED:  r_speed <= w_sp_sat;
                ST_PTERM,
                ST_ITERM,
                ST_DTERM:  r_duty  <= r_duty + w_gterm;
                ST_SCALE:  r_scale <= w_prod[39:0];
                default: begin
                end
            endcase
        end
        if (r_state == ST_ERR) begin
            r_err  <= w_err;
            r_dval <= {r_last_err[31], r_last_err} - {w_err[31], w_err};
            r_duty <= {41'd0, r_ff};
        end
        if (r_state == ST_CLAMP) begin
            if (r_mode == DRV_HALT || r_duty[63]) begin
                r_duty_c <= '0;
            end else if (|r_duty[62:23] || r_duty[22:0] > DUTY_MAX) begin
                r_duty_c <= DUTY_MAX;
            end else begin
                r_duty_c <= r_duty[22:0];
            end
        end
        if (r_state == ST_OUT && w_take) begin
            r_o_cmp   <= w_quo[15:0];
            r_o_lrev  <= r_lback;
            r_o_rrev  <= r_rback;
            r_o_speed <= r_speed;
            r_o_ltrav <= r_ldist;
            r_o_rtrav <= r_rdist;
            r_o_duty  <= r_duty_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_last_err <= '0;
            r_esum     <= '0;
            r_ldist    <= '0;
            r_rdist    <= '0;
            r_lback    <= 1'b0;
            r_rback    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_state == ST_TRAV_L && w_mdone) begin
                r_ldist <= r_ldist + {{7{w_lt[40]}}, w_lt[40:16]};
            end
            if (r_state == ST_TRAV_R && w_mdone) begin
                r_rdist <= r_rdist + {{7{w_rt[40]}}, w_rt[40:16]};
            end
            if (r_state == ST_RAMP && w_ddone) begin
                r_target <= w_tsat;
            end
            if (r_state == ST_ERR) begin
                r_esum     <= w_esat;
                r_last_err <= w_err;
            end
            if (r_state == ST_CLAMP) begin
                priority if (r_mode == DRV_FWD) begin
                    r_lback <= 1'b0;
                    r_rback <= 1'b0;
                end else if (r_mode == DRV_TURN && r_dir == DIR_LEFT) begin
                    r_lback <= 1'b1;
                    r_rback <= 1'b0;
                end else if (r_mode == DRV_TURN && r_dir == DIR_RIGHT) begin
                    r_lback <= 1'b0;
                    r_rback <= 1'b1;
                end else if (r_mode == DRV_BACK) begin
                    r_lback <= 1'b1;
                    r_rback <= 1'b1;
                end else begin
                end
            end
            if (r_state == ST_OUT && w_take) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_left_compare   = r_o_cmp;
    assign o_right_compare  = r_o_cmp;
    assign o_left_reverse   = r_o_lrev;
    assign o_right_reverse  = r_o_rrev;
    assign o_measured_speed = r_o_speed;
    assign o_left_travel    = r_o_ltrav;
    assign o_right_travel   = r_o_rtrav;
    assign o_duty_percent   = r_o_duty;

endmodule
